FILE: src/icm_pkg.sv
// ============================================================================
// icm_pkg
// Shared types, codes and helpers for the iteration convergence monitor.
// ============================================================================
package icm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [2:0] {
        VERDICT_ITERATING    = 3'd0,
        VERDICT_CONVERGED    = 3'd1,
        VERDICT_MAX_ITER     = 3'd2,
        VERDICT_INSUFFICIENT = 3'd3,
        VERDICT_BAD_NUMBER   = 3'd4,
        VERDICT_TOO_LARGE    = 3'd5,
        VERDICT_DIVERGED     = 3'd6
    } verdict_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_ACCEPTED         = 3'd0,
        REG_MAX_ITERATIONS       = 3'd1,
        REG_MAX_TRANS_CORRECTION = 3'd2,
        REG_MAX_ROT_CORRECTION   = 3'd3,
        REG_DIVERGENCE_RATIO     = 3'd4,
        REG_TRANS_THRESHOLD      = 3'd5,
        REG_ROT_THRESHOLD        = 3'd6
    } cfg_index_t;

    localparam logic [15:0] RST_MIN_ACCEPTED         = 16'd1;
    localparam logic [15:0] RST_MAX_ITERATIONS       = 16'd10;
    localparam logic [31:0] RST_MAX_TRANS_CORRECTION = 32'd65536;
    localparam logic [31:0] RST_MAX_ROT_CORRECTION   = 32'd65536;
    localparam logic [15:0] RST_DIVERGENCE_RATIO     = 16'd512;
    localparam logic [31:0] RST_TRANS_THRESHOLD      = 32'd66;
    localparam logic [31:0] RST_ROT_THRESHOLD        = 32'd66;

    localparam logic [15:0] ITER_MAX = 16'hFFFF;

    typedef struct packed {
        logic               start_new;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic [31:0]        residual_rms;
        logic [15:0]        accepted_count;
        logic               bad_number;
    } obs_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] iteration_number;
    } res_t;

    typedef struct packed {
        logic [15:0] min_accepted;
        logic [15:0] max_iterations;
        logic [31:0] max_trans_correction;
        logic [31:0] max_rot_correction;
        logic [15:0] divergence_ratio;
        logic [31:0] trans_threshold;
        logic [31:0] rot_threshold;
    } cfg_t;

    typedef struct packed {
        logic [63:0] max_trans_sq;
        logic [63:0] max_rot_sq;
        logic [63:0] trans_thr_sq;
        logic [63:0] rot_thr_sq;
    } cfg_sq_t;

    // side information carried alongside the norm pipeline
    typedef struct packed {
        logic        start_new;
        logic        bad_number;
        logic [15:0] accepted_count;
        logic [31:0] rms;
        logic [47:0] rms_prod;
    } side_t;

    // decision flags presented to the judge stage
    typedef struct packed {
        logic        start_new;
        logic        bad_number;
        logic        insufficient;
        logic        too_large;
        logic        converged;
        logic [31:0] rms;
        logic [47:0] rms_prod;
    } judge_in_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] total;
    } judge_state_t;

    function automatic logic [31:0] magnitude(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return u[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

FILE: src/iteration_convergence_monitor_unit.sv
// ============================================================================
// iteration_convergence_monitor_unit
// Judges each estimator iteration and holds a sticky convergence verdict.
// ============================================================================
//  channel | signals                        | beat
//  --------+--------------------------------+-------------------------------
//  obs     | obs_valid, obs_stall, obs      | one iteration observation
//  res     | res_valid, res_stall, res      | verdict and iteration count
//  cfg     | cfg_we, cfg_index, cfg_data    | one register write, no stall
//
//  One beat per cycle sustained while res is not stalled; an observation
//  passes the input register, the correction squares and their 64-bit
//  sums, each in its own stage, then the compare and verdict registers.
//  Reset restores the register defaults and the iterating state at once.
//  A stall on res backs up stage by stage, filling bubbles first; obs_stall
//  rises only when every stage holds a beat and the result is not taken.
// ============================================================================
module iteration_convergence_monitor_unit
    import icm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   obs_valid,
    output logic                   obs_stall,
    input  obs_t                   obs,
    output logic                   res_valid,
    input  logic                   res_stall,
    output res_t                   res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg;
    cfg_sq_t      sq;
    judge_state_t st;

    logic         s1_valid_reg;
    logic         s2_valid_reg;
    logic         s3_valid_reg;
    logic         s4_valid_reg;
    obs_t         s1_reg;
    side_t        s2_reg;
    side_t        s2_next;
    side_t        s3_reg;
    judge_in_t    s4_reg;
    judge_in_t    s4_next;
    logic [63:0]  trans_sq;
    logic [63:0]  rot_sq;

    logic         take_out;
    logic         en1;
    logic         en2;
    logic         en3;
    logic         en4;

    assign take_out  = !res_valid || !res_stall;
    assign en4       = !s4_valid_reg || take_out;
    assign en3       = !s3_valid_reg || en4;
    assign en2       = !s2_valid_reg || en3;
    assign en1       = !s1_valid_reg || en2;
    assign obs_stall = !en1;

    icm_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .sq        (sq)
    );

    icm_norm_pipe u_trans
    (
        .clk     (clk),
        .en_sq   (en2),
        .en_sum  (en3),
        .comp_x  (s1_reg.trans_x),
        .comp_y  (s1_reg.trans_y),
        .comp_z  (s1_reg.trans_z),
        .norm_sq (trans_sq)
    );

    icm_norm_pipe u_rot
    (
        .clk     (clk),
        .en_sq   (en2),
        .en_sum  (en3),
        .comp_x  (s1_reg.rot_x),
        .comp_y  (s1_reg.rot_y),
        .comp_z  (s1_reg.rot_z),
        .norm_sq (rot_sq)
    );

    always_comb
    begin
        s2_next.start_new      = s1_reg.start_new;
        s2_next.bad_number     = s1_reg.bad_number;
        s2_next.accepted_count = s1_reg.accepted_count;
        s2_next.rms            = s1_reg.residual_rms;
        s2_next.rms_prod       = s1_reg.residual_rms * cfg.divergence_ratio;

        s4_next.start_new    = s3_reg.start_new;
        s4_next.bad_number   = s3_reg.bad_number;
        s4_next.insufficient = s3_reg.accepted_count < cfg.min_accepted;
        s4_next.too_large    = (trans_sq > sq.max_trans_sq) || (rot_sq > sq.max_rot_sq);
        s4_next.converged    = (trans_sq <= sq.trans_thr_sq) && (rot_sq <= sq.rot_thr_sq);
        s4_next.rms          = s3_reg.rms;
        s4_next.rms_prod     = s3_reg.rms_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= obs_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= obs;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s2_reg;
        end
        if (en4)
        begin
            s4_reg <= s4_next;
        end
    end

    icm_judge u_judge
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .take_out         (take_out),
        .s4_valid         (s4_valid_reg),
        .s4               (s4_reg),
        .max_iterations   (cfg.max_iterations),
        .divergence_ratio (cfg.divergence_ratio),
        .res_valid        (res_valid),
        .res              (res),
        .st               (st)
    );

`ifndef SYNTHESIS
    // input held back only when the result is waiting
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        obs_stall |-> (res_valid && res_stall && s1_valid_reg && s4_valid_reg))
        else $error("obs_stall raised with room in the pipeline");

    // iterating results sit strictly inside the iteration limit
    a_iterating_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.verdict == VERDICT_ITERATING)
        |-> (res.iteration_number != 16'd0
             && res.iteration_number < cfg.max_iterations))
        else $error("iterating verdict with count outside the limit");

    // a terminal verdict repeats until a new start
    a_terminal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (take_out && s4_valid_reg && st.verdict != VERDICT_ITERATING && !s4_reg.start_new)
        |=> (res.verdict == $past(st.verdict) && res.iteration_number == $past(st.total)))
        else $error("terminal verdict not held");
`endif

endmodule

FILE: src/icm_cfg_regs.sv
// ============================================================================
// icm_cfg_regs
// Configuration register file with registered squares of the norm limits.
// ============================================================================
module icm_cfg_regs
    import icm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg,
    output cfg_sq_t                sq
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cfg_sq_t sq_reg;
    cfg_sq_t sq_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_MIN_ACCEPTED:         cfg_next.min_accepted         = cfg_data[15:0];
                REG_MAX_ITERATIONS:       cfg_next.max_iterations       = cfg_data[15:0];
                REG_MAX_TRANS_CORRECTION: cfg_next.max_trans_correction = cfg_data;
                REG_MAX_ROT_CORRECTION:   cfg_next.max_rot_correction   = cfg_data;
                REG_DIVERGENCE_RATIO:     cfg_next.divergence_ratio     = cfg_data[15:0];
                REG_TRANS_THRESHOLD:      cfg_next.trans_threshold      = cfg_data;
                REG_ROT_THRESHOLD:        cfg_next.rot_threshold        = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_accepted         <= RST_MIN_ACCEPTED;
            cfg_reg.max_iterations       <= RST_MAX_ITERATIONS;
            cfg_reg.max_trans_correction <= RST_MAX_TRANS_CORRECTION;
            cfg_reg.max_rot_correction   <= RST_MAX_ROT_CORRECTION;
            cfg_reg.divergence_ratio     <= RST_DIVERGENCE_RATIO;
            cfg_reg.trans_threshold      <= RST_TRANS_THRESHOLD;
            cfg_reg.rot_threshold        <= RST_ROT_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        sq_next.max_trans_sq = cfg_reg.max_trans_correction * cfg_reg.max_trans_correction;
        sq_next.max_rot_sq   = cfg_reg.max_rot_correction * cfg_reg.max_rot_correction;
        sq_next.trans_thr_sq = cfg_reg.trans_threshold * cfg_reg.trans_threshold;
        sq_next.rot_thr_sq   = cfg_reg.rot_threshold * cfg_reg.rot_threshold;
    end

    // refresh every cycle
    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign cfg = cfg_reg;
    assign sq  = sq_reg;

endmodule

FILE: src/icm_norm_pipe.sv
// ============================================================================
// icm_norm_pipe
// Squared Euclidean norm of a three-component correction, two stages.
// ============================================================================
module icm_norm_pipe
    import icm_pkg::*;
(
    input  logic               clk,
    input  logic               en_sq,
    input  logic               en_sum,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    output logic [63:0]        norm_sq
);

    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    logic [63:0] sq_next [3];
    logic [63:0] sq_reg  [3];
    logic [63:0] sum_next;
    logic [63:0] sum_reg;

    always_comb
    begin
        mag_x      = magnitude(comp_x);
        mag_y      = magnitude(comp_y);
        mag_z      = magnitude(comp_z);
        sq_next[0] = mag_x * mag_x;
        sq_next[1] = mag_y * mag_y;
        sq_next[2] = mag_z * mag_z;
        sum_next   = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en_sq)
        begin
            sq_reg <= sq_next;
        end
        if (en_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign norm_sq = sum_reg;

endmodule

FILE: src/icm_judge.sv
// ============================================================================
// icm_judge
// Sticky verdict, iteration count and RMS history; result register.
// ============================================================================
module icm_judge
    import icm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take_out,
    input  logic         s4_valid,
    input  judge_in_t    s4,
    input  logic [15:0]  max_iterations,
    input  logic [15:0]  divergence_ratio,
    output logic         res_valid,
    output res_t         res,
    output judge_state_t st
);

    judge_state_t st_reg;
    judge_state_t st_next;
    logic [31:0]  prev_rms_reg;
    logic [31:0]  prev_rms_next;
    logic [47:0]  prev_prod_reg;
    logic [47:0]  prev_prod_next;
    logic         res_valid_reg;
    res_t         res_reg;
    res_t         res_next;

    logic         load;
    verdict_t     verdict_in;
    logic [15:0]  total_in;
    logic [31:0]  prev_in;
    logic [47:0]  prod_in;
    logic [47:0]  refresh_prod;
    logic         record;
    logic         diverged;

    assign load = take_out && s4_valid;

    always_comb
    begin
        verdict_in   = s4.start_new ? VERDICT_ITERATING : st_reg.verdict;
        total_in     = s4.start_new ? 16'd0 : st_reg.total;
        prev_in      = s4.start_new ? 32'd0 : prev_rms_reg;
        prod_in      = s4.start_new ? 48'd0 : prev_prod_reg;
        refresh_prod = divergence_ratio * prev_rms_reg;

        record           = (verdict_in == VERDICT_ITERATING);
        st_next.verdict  = verdict_in;
        st_next.total    = total_in;
        prev_rms_next    = prev_in;
        diverged         = 1'b0;

        if (record)
        begin
            if (total_in != ITER_MAX)
            begin
                st_next.total = total_in + 16'd1;
            end
            prev_rms_next = s4.rms;
            diverged = (st_next.total > 16'd1) && (prev_in != 32'd0)
                       && ({8'd0, s4.rms, 8'd0} > prod_in);

            if (s4.bad_number)
            begin
                st_next.verdict = VERDICT_BAD_NUMBER;
            end
            else if (s4.insufficient)
            begin
                st_next.verdict = VERDICT_INSUFFICIENT;
            end
            else if (s4.too_large)
            begin
                st_next.verdict = VERDICT_TOO_LARGE;
            end
            else if (diverged)
            begin
                st_next.verdict = VERDICT_DIVERGED;
            end
            else if (s4.converged)
            begin
                st_next.verdict = VERDICT_CONVERGED;
            end
            else if (st_next.total >= max_iterations)
            begin
                st_next.verdict = VERDICT_MAX_ITER;
            end
        end

        prev_prod_next            = (load && record) ? s4.rms_prod : refresh_prod;
        res_next.verdict          = st_next.verdict;
        res_next.iteration_number = st_next.total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.verdict <= VERDICT_ITERATING;
            st_reg.total   <= 16'd0;
            prev_rms_reg   <= 32'd0;
            prev_prod_reg  <= 48'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_prod_reg <= prev_prod_next;
            if (take_out)
            begin
                res_valid_reg <= s4_valid;
            end
            if (load)
            begin
                st_reg       <= st_next;
                prev_rms_reg <= prev_rms_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign st        = st_reg;

endmodule

FILE: dv/icm_verdict_checker.sv
// ============================================================================
// icm_verdict_checker
// Watches the observation, result and register channels of the iteration
// convergence monitor. Predicts the verdict and iteration count of every
// accepted observation and compares each accepted result, field by field,
// with the oldest prediction still waiting.
// ============================================================================
module icm_verdict_checker
    import icm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   obs_valid,
    input  logic                   obs_stall,
    input  obs_t                   obs,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  res_t                   res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_checked
);

    cfg_t        regs;
    verdict_t    held_verdict;
    logic [15:0] iter_count;
    logic [31:0] last_rms;
    res_t        expected_verdicts[$];
    int          fail_total = 0;
    int          checked_total = 0;

    function automatic logic [63:0] abs_wide(input logic signed [31:0] v);
        logic [31:0] u;
        u = v[31] ? 32'(-v) : 32'(v);
        return {32'd0, u};
    endfunction

    function automatic logic [63:0] norm_sq(input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic signed [31:0] c);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mc;
        ma = abs_wide(a);
        mb = abs_wide(b);
        mc = abs_wide(c);
        return ma * ma + mb * mb + mc * mc;
    endfunction

    function automatic res_t judge_observation(input obs_t o);
        logic [63:0] t2;
        logic [63:0] r2;
        logic [63:0] mt;
        logic [63:0] mr;
        logic [63:0] tt;
        logic [63:0] rt;
        logic [63:0] grown;
        logic [63:0] allowed;
        logic [31:0] prior;
        res_t        r;
        if (o.start_new)
        begin
            held_verdict = VERDICT_ITERATING;
            iter_count   = '0;
            last_rms     = '0;
        end
        if (held_verdict == VERDICT_ITERATING)
        begin
            t2      = norm_sq(o.trans_x, o.trans_y, o.trans_z);
            r2      = norm_sq(o.rot_x, o.rot_y, o.rot_z);
            mt      = {32'd0, regs.max_trans_correction};
            mr      = {32'd0, regs.max_rot_correction};
            tt      = {32'd0, regs.trans_threshold};
            rt      = {32'd0, regs.rot_threshold};
            prior   = last_rms;
            grown   = {24'd0, o.residual_rms, 8'd0};
            allowed = {48'd0, regs.divergence_ratio} * {32'd0, prior};
            if (iter_count != ITER_MAX)
                iter_count = iter_count + 16'd1;
            last_rms = o.residual_rms;
            if (o.bad_number)
                held_verdict = VERDICT_BAD_NUMBER;
            else if (o.accepted_count < regs.min_accepted)
                held_verdict = VERDICT_INSUFFICIENT;
            else if (t2 > mt * mt || r2 > mr * mr)
                held_verdict = VERDICT_TOO_LARGE;
            else if (iter_count > 16'd1 && prior != '0 && grown > allowed)
                held_verdict = VERDICT_DIVERGED;
            else if (t2 <= tt * tt && r2 <= rt * rt)
                held_verdict = VERDICT_CONVERGED;
            else if (iter_count >= regs.max_iterations)
                held_verdict = VERDICT_MAX_ITER;
        end
        r.verdict          = held_verdict;
        r.iteration_number = iter_count;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t fresh;
        if (!rst_n)
        begin
            regs.min_accepted         = RST_MIN_ACCEPTED;
            regs.max_iterations       = RST_MAX_ITERATIONS;
            regs.max_trans_correction = RST_MAX_TRANS_CORRECTION;
            regs.max_rot_correction   = RST_MAX_ROT_CORRECTION;
            regs.divergence_ratio     = RST_DIVERGENCE_RATIO;
            regs.trans_threshold      = RST_TRANS_THRESHOLD;
            regs.rot_threshold        = RST_ROT_THRESHOLD;
            held_verdict              = VERDICT_ITERATING;
            iter_count                = '0;
            last_rms                  = '0;
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_MIN_ACCEPTED:         regs.min_accepted = cfg_data[15:0];
                    REG_MAX_ITERATIONS:       regs.max_iterations = cfg_data[15:0];
                    REG_MAX_TRANS_CORRECTION: regs.max_trans_correction = cfg_data;
                    REG_MAX_ROT_CORRECTION:   regs.max_rot_correction = cfg_data;
                    REG_DIVERGENCE_RATIO:     regs.divergence_ratio = cfg_data[15:0];
                    REG_TRANS_THRESHOLD:      regs.trans_threshold = cfg_data;
                    REG_ROT_THRESHOLD:        regs.rot_threshold = cfg_data;
                    default: ;
                endcase
            end
            if (obs_valid && !obs_stall)
            begin
                fresh             = judge_observation(obs);
                expected_verdicts = {expected_verdicts, fresh};
            end
            if (res_valid && !res_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result beat, verdict %0d count %0d",
                             $time, res.verdict, res.iteration_number);
                    fail_total++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    checked_total++;
                    if (res.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict mismatch, expected %0d actual %0d",
                                 $time, want.verdict, res.verdict);
                        fail_total++;
                    end
                    if (res.iteration_number !== want.iteration_number)
                    begin
                        $display("%0t: iteration count mismatch, expected %0d actual %0d",
                                 $time, want.iteration_number, res.iteration_number);
                        fail_total++;
                    end
                end
            end
        end
        mismatches      <= fail_total;
        outstanding     <= expected_verdicts.size();
        results_checked <= checked_total;
    end

endmodule

FILE: dv/tb_top.sv
// ============================================================================
// tb_top
// Stimulus for the iteration convergence monitor: directed observations for
// every verdict and boundary, then well-formed estimator runs with random
// content mixed with noise, under several register settings including the
// extremes.
// Both channels idle at random; the result side holds off once for long.
// ============================================================================
module tb_top;
    import icm_pkg::*;

    localparam int RUN_LIMIT    = 100_000;
    localparam int DRAIN_CYCLES = 8;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   obs_valid = 1'b0;
    logic                   obs_stall;
    obs_t                   obs = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_t                   res;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          results_checked;
    int          cycle_count = 0;
    int          tx_gap_max = 3;
    int          obs_sent = 0;
    int          reg_writes = 0;
    cfg_t        active_regs = '0;
    logic [31:0] rms_track = 32'd1000;

    iteration_convergence_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .obs_valid (obs_valid),
        .obs_stall (obs_stall),
        .obs       (obs),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    icm_verdict_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .obs_valid       (obs_valid),
        .obs_stall       (obs_stall),
        .obs             (obs),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic obs_t observation(input bit start,
                                         input logic signed [31:0] tx,
                                         input logic signed [31:0] ty,
                                         input logic signed [31:0] tz,
                                         input logic signed [31:0] rx,
                                         input logic signed [31:0] ry,
                                         input logic signed [31:0] rz,
                                         input logic [31:0] rms,
                                         input logic [15:0] acc,
                                         input bit nf);
        obs_t o;
        o.start_new      = start;
        o.trans_x        = tx;
        o.trans_y        = ty;
        o.trans_z        = tz;
        o.rot_x          = rx;
        o.rot_y          = ry;
        o.rot_z          = rz;
        o.residual_rms   = rms;
        o.accepted_count = acc;
        o.bad_number     = nf;
        return o;
    endfunction

    function automatic int pick_scale();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 0;
        else if (pick < 88)
            return 1;
        return 2;
    endfunction

    function automatic logic signed [31:0] draw_comp(input int scale);
        logic [31:0] m;
        if (scale == 0)
            m = $urandom_range(0, 40);
        else if (scale == 1)
            m = $urandom_range(0, 32'h0010_0000);
        else
            m = $urandom;
        if ($urandom_range(0, 1) == 1)
            m = -m;
        return m;
    endfunction

    // one step of a plausible estimator run: random corrections, mostly shrinking RMS
    function automatic obs_t next_iteration(input bit first);
        obs_t        o;
        int          ts;
        int          rs;
        int          pick;
        int          acc;
        logic [63:0] scaled;
        ts = pick_scale();
        rs = pick_scale();
        o.start_new = first;
        o.trans_x   = draw_comp(ts);
        o.trans_y   = draw_comp(ts);
        o.trans_z   = draw_comp(ts);
        o.rot_x     = draw_comp(rs);
        o.rot_y     = draw_comp(rs);
        o.rot_z     = draw_comp(rs);
        if (first)
            rms_track = $urandom_range(1, 32'h0100_0000);
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                scaled = {32'd0, rms_track} * $urandom_range(180, 260) / 256;
            else if (pick < 95)
                scaled = {32'd0, rms_track} * $urandom_range(2, 8);
            else
                scaled = '0;
            rms_track = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
        end
        o.residual_rms = rms_track;
        if ($urandom_range(0, 99) < 85)
        begin
            acc = int'(active_regs.min_accepted) + int'($urandom_range(0, 50));
            if (acc > 65535)
                acc = 65535;
            o.accepted_count = acc[15:0];
        end
        else
            o.accepted_count = 16'($urandom_range(0, 16'hFFFF));
        o.bad_number = ($urandom_range(0, 39) == 0);
        return o;
    endfunction

    function automatic obs_t noise_obs();
        obs_t o;
        o.start_new      = 1'($urandom_range(0, 1));
        o.trans_x        = $urandom;
        o.trans_y        = $urandom;
        o.trans_z        = $urandom;
        o.rot_x          = $urandom;
        o.rot_y          = $urandom;
        o.rot_z          = $urandom;
        o.residual_rms   = $urandom;
        o.accepted_count = 16'($urandom);
        o.bad_number     = ($urandom_range(0, 3) == 0);
        return o;
    endfunction

    task automatic send_beat(input obs_t o);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            obs_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        obs       <= o;
        obs_valid <= 1'b1;
        do @(posedge clk); while (obs_stall);
        obs_sent++;
    endtask

    task automatic program_regs(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [7];
        cfg_index_t            idx;
        vals[REG_MIN_ACCEPTED]         = {16'd0, c.min_accepted};
        vals[REG_MAX_ITERATIONS]       = {16'd0, c.max_iterations};
        vals[REG_MAX_TRANS_CORRECTION] = c.max_trans_correction;
        vals[REG_MAX_ROT_CORRECTION]   = c.max_rot_correction;
        vals[REG_DIVERGENCE_RATIO]     = {16'd0, c.divergence_ratio};
        vals[REG_TRANS_THRESHOLD]      = c.trans_threshold;
        vals[REG_ROT_THRESHOLD]        = c.rot_threshold;
        idx = idx.first();
        repeat (idx.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[idx];
            @(posedge clk);
            reg_writes++;
            idx = idx.next();
        end
        cfg_we      <= 1'b0;
        active_regs = c;
    endtask

    task automatic settle();
        obs_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_items(input int count);
        int left;
        left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 30 == 0)
                tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            if ($urandom_range(0, 9) < 8)
            begin
                send_beat(next_iteration(left == 0));
                left = (left == 0) ? int'($urandom_range(1, 14)) - 1 : left - 1;
            end
            else
                send_beat(noise_obs());
        end
        tx_gap_max = 3;
    endtask

    // result side: random hold per beat, calm stretches, one long hold-off
    initial
    begin : result_sink
        int  hold;
        int  sunk;
        bit  quiet;
        sunk  = 0;
        quiet = 1'b0;
        forever
        begin
            if (sunk % 25 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            hold = quiet ? 0 : $urandom_range(0, 3);
            if (sunk == 200)
                hold = 80;
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
            sunk++;
        end
    end

    initial
    begin : stimulus
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        send_beat(observation(0, 0, 0, 0, 0, 0, 0, 1000, 1, 0));
        send_beat(observation(0, 5, 5, 5, 0, 0, 0, 1000, 1, 0));
        send_beat(observation(1, 0, 0, 0, 0, 0, 0, 1000, 1, 1));
        send_beat(observation(1, 0, 0, 0, 0, 0, 0, 1000, 0, 0));
        send_beat(observation(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                              0, 0, 0, 1000, 16'hFFFF, 0));
        send_beat(observation(1, 0, 0, 0, 0, 0, 65537, 1000, 1, 0));
        send_beat(observation(1, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1));
        send_beat(observation(1, 66, 0, 0, 0, -66, 0, 500, 1, 0));
        send_beat(observation(1, 65536, 0, 0, 0, 0, 0, 1000, 1, 0));
        send_beat(observation(0, 40000, 0, 0, 0, 0, 0, 2000, 1, 0));
        send_beat(observation(0, 40000, 0, 0, 0, 0, 0, 4001, 1, 0));
        send_beat(observation(1, 1000, 0, 0, 0, 0, 0, 0, 1, 0));
        for (int n = 0; n < 9; n++)
            send_beat(observation(0, 1000, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0));
        send_beat(observation(0, 0, 0, 0, 0, 0, 0, 1000, 1, 0));
        random_items(100);

        settle();
        program_regs(cfg_t'{16'd0, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'd0, 32'd0, 32'd0});
        random_items(60);

        settle();
        program_regs(cfg_t'{16'hFFFF, 16'hFFFF, 32'd0, 32'd0,
                            16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        random_items(60);

        settle();
        program_regs(cfg_t'{16'd8, 16'd6, 32'h0040_0000, 32'h0010_0000,
                            16'd300, 32'd2000, 32'd1500});
        random_items(80);

        settle();
        program_regs(cfg_t'{16'd1, 16'd5, 32'h0100_0000, 32'h0100_0000,
                            16'd0, 32'd66, 32'd66});
        random_items(40);

        settle();
        program_regs(cfg_t'{16'd0, 16'd0, 32'h0010_0000, 32'h0010_0000,
                            16'd256, 32'd0, 32'd0});
        send_beat(observation(1, 100, 0, 0, 0, 0, 0, 1000, 0, 0));
        send_beat(observation(1, 0, 0, 0, 0, 0, 0, 1000, 0, 0));
        random_items(40);

        settle();
        $display("covered %0d observation beats and %0d result beats, %0d register writes",
                 obs_sent, results_checked, reg_writes);
        $display("every verdict, register extremes and one long result hold-off");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
